// File: src/hcbcm_pkg.sv
package hcbcm_pkg;

  localparam int unsigned NumThr = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [16:0] RunMax = 17'h1FFFF;

  localparam logic [NumThr-1:0][31:0] ThrReset = {
    32'd128, 32'd32, 32'd16, 32'd8, 32'd4, 32'd3, 32'd2
  };
  localparam logic FeedbackReset = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THR1     = 3'd0,
    CFG_THR2     = 3'd1,
    CFG_THR3     = 3'd2,
    CFG_THR4     = 3'd3,
    CFG_THR5     = 3'd4,
    CFG_THR6     = 3'd5,
    CFG_THR7     = 3'd6,
    CFG_FEEDBACK = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } back_state_e;

  typedef struct packed {
    logic [15:0] edge_index;
    logic [31:0] hit_count;
    logic        last_edge;
  } in_item_t;

  typedef struct packed {
    logic        new_edge_found;
    logic        new_bucket_found;
    logic        feedback;
    logic [19:0] filled_bucket_total;
    logic [16:0] covered_edge_total;
    logic [16:0] run_hit_edges;
  } out_item_t;

  typedef struct packed {
    logic                we;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // classified beat between front and back
  typedef struct packed {
    logic        hit;
    logic [15:0] edge_index;
    logic [7:0]  bucket_bit;
    logic        last;
  } op_t;

endpackage

// File: src/hcbcm_fifo.sv
module hcbcm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: src/hcbcm_front.sv
module hcbcm_front #(
  parameter int unsigned MapSize = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcbcm_pkg::cfg_wr_t  cfg_i,
  input  hcbcm_pkg::in_item_t item_i,
  output hcbcm_pkg::op_t      op_o
);

  import hcbcm_pkg::*;

  logic [NumThr-1:0][31:0] thr_q;
  logic                    in_range;
  logic [7:0]              bucket_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_i.we && cfg_i.idx != CFG_FEEDBACK) begin
      thr_q[cfg_i.idx] <= cfg_i.data;
    end
  end

  assign in_range = ({16'd0, item_i.edge_index} < 32'(MapSize));

  // highest bucket whose minimum is met wins; none met means bucket zero
  always_comb begin
    bucket_bit = 8'd1;
    for (int b = 1; b <= NumThr; b++) begin
      if (item_i.hit_count >= thr_q[b-1]) begin
        bucket_bit = 8'd1 << b;
      end
    end
  end

  assign op_o.hit        = in_range && (item_i.hit_count != '0);
  assign op_o.edge_index = item_i.edge_index;
  assign op_o.bucket_bit = bucket_bit;
  assign op_o.last       = item_i.last_edge;

endmodule

// File: src/hcbcm_back.sv
module hcbcm_back #(
  parameter int unsigned MapSize = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcbcm_pkg::cfg_wr_t   cfg_i,
  input  hcbcm_pkg::op_t       op_i,
  input  logic                 op_valid_i,
  output logic                 op_pop_o,
  output hcbcm_pkg::out_item_t res_o,
  output logic                 res_push_o,
  input  logic                 res_full_i,
  output logic                 busy_o
);

  import hcbcm_pkg::*;

  localparam int unsigned AddrW = $clog2(MapSize);
  localparam logic [AddrW-1:0] ClrLast = AddrW'(MapSize - 1);

  back_state_e state_q, state_d;
  op_t         op_q;
  logic [AddrW-1:0] clr_q;
  logic [7:0]  bmap_q [MapSize];
  logic [7:0]  rd_q;
  logic [19:0] filled_q, filled_d;
  logic [16:0] covered_q, covered_d;
  logic [16:0] run_cnt_q, run_cnt_d;
  logic        run_edge_q, run_edge_d;
  logic        run_bucket_q, run_bucket_d;
  logic        fb_q;

  logic             mem_we, mem_re, apply;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             new_edge, new_bucket;

  assign new_edge   = op_q.hit && (rd_q == 8'd0);
  assign new_bucket = op_q.hit && ((rd_q & op_q.bucket_bit) == 8'd0);

  assign covered_d    = covered_q + 17'(new_edge);
  assign filled_d     = filled_q + 20'(new_bucket);
  assign run_edge_d   = run_edge_q | new_edge;
  assign run_bucket_d = run_bucket_q | new_bucket;
  assign run_cnt_d    = (op_q.hit && run_cnt_q != RunMax) ? run_cnt_q + 17'd1 : run_cnt_q;

  assign res_o.new_edge_found      = run_edge_d;
  assign res_o.new_bucket_found    = run_bucket_d;
  assign res_o.feedback            = fb_q ? run_bucket_d : run_edge_d;
  assign res_o.filled_bucket_total = filled_d;
  assign res_o.covered_edge_total  = covered_d;
  assign res_o.run_hit_edges       = run_cnt_d;

  assign busy_o = (state_q == BK_CLEAR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: begin
        if (clr_q == ClrLast) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (op_valid_i) begin
          state_d = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (!(op_q.last && res_full_i)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_CLEAR;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = AddrW'(op_q.edge_index);
    mem_wdata  = rd_q | op_q.bucket_bit;
    op_pop_o   = 1'b0;
    res_push_o = 1'b0;
    apply      = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'd0;
      end
      BK_IDLE: begin
        op_pop_o = op_valid_i;
        mem_re   = op_valid_i;
      end
      BK_UPDATE: begin
        if (!(op_q.last && res_full_i)) begin
          apply      = 1'b1;
          res_push_o = op_q.last;
          mem_we     = new_bucket;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_CLEAR;
      clr_q        <= '0;
      filled_q     <= '0;
      covered_q    <= '0;
      run_cnt_q    <= '0;
      run_edge_q   <= 1'b0;
      run_bucket_q <= 1'b0;
      fb_q         <= FeedbackReset;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cfg_i.we && cfg_i.idx == CFG_FEEDBACK) begin
        fb_q <= cfg_i.data[0];
      end
      if (apply) begin
        filled_q  <= filled_d;
        covered_q <= covered_d;
        if (op_q.last) begin
          run_cnt_q    <= '0;
          run_edge_q   <= 1'b0;
          run_bucket_q <= 1'b0;
        end else begin
          run_cnt_q    <= run_cnt_d;
          run_edge_q   <= run_edge_d;
          run_bucket_q <= run_bucket_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bmap_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= bmap_q[AddrW'(op_i.edge_index)];
    end
  end

  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_CLEAR |-> !op_pop_o)
    else $error("beat taken during map clear");

  a_push_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> op_q.last && !res_full_i && state_q == BK_UPDATE)
    else $error("result pushed without last beat or space");

  a_edge_implies_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply && new_edge |-> new_bucket)
    else $error("new edge without new bucket bit");

  a_update_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_UPDATE && mem_we |-> mem_wdata != rd_q)
    else $error("map write does not add a bucket bit");

endmodule

// File: src/hit_count_bucket_coverage_map.sv
// Hit-count bucket coverage map. Push one beat per edge (index, hit count, last
// flag); a nonzero count in the map sets its bucket bit, and the beat marked last
// yields one result with the run flags and map totals. After reset, full stays
// high while the map is cleared one entry per cycle; config writes are taken
// during that time. Each beat then passes through the map unit as a registered
// read, then a write-back, and the next beat is taken only after that write-back.
// Two-entry queues sit between the classifier and the map unit and on the
// result side. Config writes must only occur while idle.
module hit_count_bucket_coverage_map #(
  parameter int unsigned MAP_SIZE = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  hcbcm_pkg::in_item_t                    in_data_i,
  output logic                                   empty,
  input  logic                                   pop,
  output hcbcm_pkg::out_item_t                   out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [hcbcm_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [hcbcm_pkg::CfgDataW-1:0]         cfg_wdata_i
);

  import hcbcm_pkg::*;

  cfg_wr_t   cfg;
  op_t       front_op, back_op;
  out_item_t res;
  logic      mid_full, mid_empty, mid_pop;
  logic      res_push, res_full;
  logic      busy;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg.data = cfg_wdata_i;

  assign full = mid_full || busy;

  hcbcm_front #(
    .MapSize(MAP_SIZE)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .item_i(in_data_i),
    .op_o  (front_op)
  );

  hcbcm_fifo #(
    .Width($bits(op_t)),
    .Depth(2)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full),
    .data_i (front_op),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .data_o (back_op),
    .empty_o(mid_empty)
  );

  hcbcm_back #(
    .MapSize(MAP_SIZE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .op_i      (back_op),
    .op_valid_i(!mid_empty),
    .op_pop_o  (mid_pop),
    .res_o     (res),
    .res_push_o(res_push),
    .res_full_i(res_full),
    .busy_o    (busy)
  );

  hcbcm_fifo #(
    .Width($bits(out_item_t)),
    .Depth(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule
